>>> src/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
`default_nettype none
package bfa_pkg;

  localparam int FRAME_W      = 12;
  localparam int CFG_W        = 13;
  localparam int WORD_BITS    = 32;
  localparam int BIT_W        = 5;
  localparam int TOTAL_RESET  = 4096;
  localparam logic [WORD_BITS-1:0] ALL_USED = 32'hFFFF_FFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC    = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_FREED    = 2'd3
  } bfa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE
  } bfa_state_t;

  typedef struct packed {
    logic               cmd;
    logic [FRAME_W-1:0] entry_frame;
    logic               supervisor;
    logic               writable;
  } bfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               rw;
    logic               user;
    bfa_status_t        status;
  } bfa_out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bfa_mem_ctl_t;

  typedef struct packed {
    logic                 full;
    logic [BIT_W-1:0]     low_bit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
  } bfa_word_res_t;

endpackage
`default_nettype wire

>>> src/bfa_word_unit.sv
// bitmap word unit: full check, lowest clear bit, bit set and bit clear
`default_nettype none
module bfa_word_unit import bfa_pkg::*; (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [BIT_W-1:0]     bit_sel,
  output bfa_word_res_t             res
);

  logic [BIT_W-1:0] low;

  // lowest clear bit wins
  always_comb begin
    low = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        low = BIT_W'(i);
      end
    end
  end

  always_comb begin
    res.full     = (word == ALL_USED);
    res.low_bit  = low;
    res.set_word = word | (WORD_BITS'(1) << low);
    res.clr_word = word & ~(WORD_BITS'(1) << bit_sel);
  end

endmodule
`default_nettype wire

>>> src/bfa_bitmap.sv
// used/free bitmap memory with fill count standing in for reset clear
`default_nettype none
module bfa_bitmap import bfa_pkg::*; #(
  parameter int WORDS = 128,
  parameter int AW    = 7,
  parameter int CW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bfa_mem_ctl_t         ctl,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0]      rd_data,
  output logic [CW-1:0]             fill_cnt
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 blank_r;
  logic [CW-1:0]        fill_r;
  logic [CW-1:0]        fill_nxt;

  // words at or above the fill count were never written and read as zero
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.wr_en && (CW'(wr_addr) == fill_r)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
      blank_r <= (CW'(rd_addr) >= fill_r);
    end
  end

  assign rd_data  = blank_r ? '0 : rdata_r;
  assign fill_cnt = fill_r;

endmodule
`default_nettype wire

>>> src/bitmap_frame_allocator.sv
// top level: first-fit physical frame allocator over a used/free bitmap
`default_nettype none
// A request is taken when start is high and busy is low; its one result
// appears for exactly one cycle on out_res, marked by out_strobe, and the
// receiver cannot stall it. An allocate request for an entry that already
// holds a frame, an allocate request while every searchable word is known
// to be full, a free of an empty entry and a free of a frame beyond the
// bitmap give their result in the cycle after acceptance. A free reads
// the bitmap word, then writes it back. Any other allocation reads
// bitmap words from the hint upward, stepping over fully used words,
// until one has a free bit, then sets that bit: the bitmap is read one
// 32-bit word per cycle through its read port. A hint register keeps the
// lowest word that may still hold a free frame, so in steady use the scan
// starts on a word with a free bit. No clearing pass follows reset: a fill
// count marks the words never written, which read as zero, so requests are
// taken right away. total_frames must be written on the cfg channel (always
// ready) only while the block is idle, which the block does not enforce;
// only whole words below min(total_frames, MAX_FRAMES) are searched.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_FRAMES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             start,
  output logic                  busy,
  input  wire bfa_in_t          in_req,
  // result channel
  output logic                  out_strobe,
  output bfa_out_t              out_res,
  // configuration channel: total_frames
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW      = $clog2(WORDS + 1);
  localparam int LIM_RST = ((TOTAL_RESET < MAX_FRAMES) ? TOTAL_RESET : MAX_FRAMES) / WORD_BITS;

  bfa_state_t           state_r, state_nxt;
  bfa_in_t              req_r, req_nxt;
  logic [CW-1:0]        scan_w_r, scan_w_nxt;
  logic [CW-1:0]        hint_r, hint_nxt;
  logic [CW-1:0]        words_lim_r, words_lim_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  bfa_out_t             out_res_r, out_res_nxt;

  bfa_mem_ctl_t         mem_ctl;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] wr_data;
  logic [CW-1:0]        fill_cnt;
  bfa_word_res_t        word_res;

  logic                 accept;
  logic                 entry_zero;
  logic                 entry_in_map;
  logic [CW-1:0]        entry_word;
  logic [CW-1:0]        scan_next;
  logic [31:0]          cfg_lim;

  assign accept       = start && !busy;
  assign entry_zero   = (in_req.entry_frame == '0);
  assign entry_in_map = (32'(in_req.entry_frame) < 32'(MAX_FRAMES));
  assign entry_word   = CW'(in_req.entry_frame[FRAME_W-1:BIT_W]);
  assign scan_next    = scan_w_r + 1'b1;

  // ---------------------------------------------------------------
  // configuration: keep the number of searchable words
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_lim   = (32'(cfg_data) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : 32'(cfg_data);

  always_comb begin
    words_lim_nxt = words_lim_r;
    if (cfg_valid && cfg_ready) begin
      words_lim_nxt = CW'(cfg_lim >> BIT_W);
    end
  end

  // ---------------------------------------------------------------
  // shared word unit and bitmap
  // ---------------------------------------------------------------
  bfa_word_unit u_word (
    .word    (rd_data),
    .bit_sel (req_r.entry_frame[BIT_W-1:0]),
    .res     (word_res)
  );

  assign wr_data = (state_r == S_FREE) ? word_res.clr_word : word_res.set_word;

  bfa_bitmap #(
    .WORDS (WORDS),
    .AW    (AW),
    .CW    (CW)
  ) u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_addr  (scan_w_nxt[AW-1:0]),
    .wr_addr  (scan_w_r[AW-1:0]),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .fill_cnt (fill_cnt)
  );

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_req.cmd == CMD_ALLOC && entry_zero && hint_r < words_lim_r) begin
          state_nxt = S_SCAN;
        end else if (accept && in_req.cmd == CMD_FREE && !entry_zero && entry_in_map) begin
          state_nxt = S_FREE;
        end
      end
      S_SCAN: begin
        // stay while stepping over full words inside the limit
        if (!word_res.full || scan_next >= words_lim_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // sequencer: datapath, memory control and result
  // ---------------------------------------------------------------
  always_comb begin
    req_nxt        = req_r;
    scan_w_nxt     = scan_w_r;
    hint_nxt       = hint_r;
    mem_ctl        = '0;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '{frame: '0, present: 1'b0, rw: 1'b0, user: 1'b0, status: ST_NOCHANGE};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_req;
          if (in_req.cmd == CMD_ALLOC) begin
            if (!entry_zero) begin
              // entry already holds a frame
              out_strobe_nxt    = 1'b1;
              out_res_nxt.frame = in_req.entry_frame;
            end else if (hint_r >= words_lim_r) begin
              out_strobe_nxt     = 1'b1;
              out_res_nxt.status = ST_FULL;
            end else begin
              scan_w_nxt    = hint_r;
              mem_ctl.rd_en = 1'b1;
            end
          end else begin
            if (entry_zero) begin
              out_strobe_nxt = 1'b1;
            end else if (!entry_in_map) begin
              // frame beyond the bitmap: nothing to clear
              out_strobe_nxt     = 1'b1;
              out_res_nxt.status = ST_FREED;
            end else begin
              scan_w_nxt    = entry_word;
              mem_ctl.rd_en = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (!word_res.full) begin
          mem_ctl.wr_en       = 1'b1;
          out_strobe_nxt      = 1'b1;
          out_res_nxt.frame   = FRAME_W'({scan_w_r[AW-1:0], word_res.low_bit});
          out_res_nxt.present = 1'b1;
          out_res_nxt.rw      = req_r.writable;
          out_res_nxt.user    = ~req_r.supervisor;
          out_res_nxt.status  = ST_ALLOC;
        end else begin
          // every word below the hint is full
          hint_nxt = scan_next;
          if (scan_next >= words_lim_r) begin
            out_strobe_nxt     = 1'b1;
            out_res_nxt.status = ST_FULL;
          end else begin
            scan_w_nxt    = scan_next;
            mem_ctl.rd_en = 1'b1;
          end
        end
      end
      S_FREE: begin
        mem_ctl.wr_en      = 1'b1;
        out_strobe_nxt     = 1'b1;
        out_res_nxt.status = ST_FREED;
        if (scan_w_r < hint_r) begin
          hint_nxt = scan_w_r;
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hint_r       <= '0;
      words_lim_r  <= CW'(LIM_RST);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hint_r       <= hint_nxt;
      words_lim_r  <= words_lim_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    scan_w_r  <= scan_w_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // an accepted request either keeps the block busy or returns at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request neither busy nor answered");

  // hint never points past the written part of the bitmap
  a_hint_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= fill_cnt)
    else $error("allocation hint beyond fill count");

  // a scan only visits searchable words
  a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_w_r < words_lim_r))
    else $error("scan word outside searchable range");

  // a fresh allocation only comes out of a scan
  a_alloc_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.status == ST_ALLOC) |-> ($past(state_r) == S_SCAN))
    else $error("allocation result without a scan");

endmodule
`default_nettype wire

>>> bench/bfa_checker.sv
// result checker for the frame allocator: bitmap model, expected queue, field compare
module bfa_alloc_checker import bfa_pkg::*; #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  bfa_in_t          in_req,
  input  logic             out_strobe,
  input  bfa_out_t         out_res,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               outstanding,
  output int               fail_count
);

  bit          frame_used [MAX_FRAMES];
  int unsigned total_frames;
  bfa_out_t    expected_entries [$];

  task automatic report(string what, int want, int got);
    if (fail_count < 40) begin
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
    end
    fail_count++;
  endtask

  // outcome of one request; marks or clears the frame in the bitmap
  function automatic bfa_out_t alloc_outcome(bfa_in_t r);
    bfa_out_t    res;
    int unsigned span;
    res = '0;
    res.status = ST_NOCHANGE;
    if (r.cmd == CMD_ALLOC) begin
      if (r.entry_frame != '0) begin
        res.frame = r.entry_frame;
      end else begin
        // only whole words below the clamped count are searched
        span = ((total_frames > MAX_FRAMES) ? MAX_FRAMES : total_frames) / WORD_BITS;
        span = span * WORD_BITS;
        res.status = ST_FULL;
        for (int f = 0; f < span; f++) begin
          if (!frame_used[f]) begin
            frame_used[f] = 1'b1;
            res.frame = FRAME_W'(f);
            res.present = 1'b1;
            res.rw = r.writable;
            res.user = ~r.supervisor;
            res.status = ST_ALLOC;
            break;
          end
        end
      end
    end else if (r.entry_frame != '0) begin
      if (r.entry_frame < MAX_FRAMES) frame_used[r.entry_frame] = 1'b0;
      res.status = ST_FREED;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    bfa_out_t want;
    if (!rst_n) begin
      frame_used = '{default: 1'b0};
      total_frames = TOTAL_RESET;
      expected_entries.delete();
      outstanding <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_entries.size() == 0) begin
          report("result with no request waiting", 0, out_res);
        end else begin
          want = expected_entries.pop_front();
          if (out_res.frame !== want.frame) report("frame", want.frame, out_res.frame);
          if (out_res.present !== want.present) report("present", want.present, out_res.present);
          if (out_res.rw !== want.rw) report("rw", want.rw, out_res.rw);
          if (out_res.user !== want.user) report("user", want.user, out_res.user);
          if (out_res.status !== want.status) report("status", want.status, out_res.status);
        end
      end
      if (start && !busy) expected_entries.push_back(alloc_outcome(in_req));
      if (cfg_valid && cfg_ready) total_frames = cfg_data;
      outstanding <= expected_entries.size();
    end
  end

endmodule

>>> bench/bitmap_frame_allocator_tb.sv
// stimulus and verdict for the bitmap frame allocator
module bitmap_frame_allocator_tb import bfa_pkg::*;;

  localparam int MAX_FRAMES  = 4096;
  localparam int IN_W        = $bits(bfa_in_t);
  // worst case is far below this: ~400 requests, each at most a full
  // word scan plus a long sender gap
  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  bfa_in_t          in_req    = '0;
  logic             out_strobe;
  bfa_out_t         out_res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int outstanding;
  int fail_count;
  int cycle_count = 0;
  int gap_pct     = 0;

  // frames handed out and not yet freed by the stimulus
  logic [FRAME_W-1:0] held_frames [$];

  bitmap_frame_allocator #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  bfa_alloc_checker #(.MAX_FRAMES(MAX_FRAMES)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // collect granted frames mid-cycle so frees can target real allocations;
  // frame zero reads back as no frame, so it is never freed by entry
  always @(negedge clk) begin
    if (rst_n && out_strobe && out_res.status == ST_ALLOC && out_res.frame != '0) begin
      held_frames.push_back(out_res.frame);
    end
  end

  function automatic bfa_in_t make_req(logic cmd, logic [FRAME_W-1:0] entry, logic kern,
                                       logic wr);
    bfa_in_t r;
    r.cmd = cmd;
    r.entry_frame = entry;
    r.supervisor = kern;
    r.writable = wr;
    return r;
  endfunction

  // mostly well-formed traffic: fresh allocations and frees of held frames,
  // with no-change requests, stray frees and raw noise mixed in
  function automatic bfa_in_t random_request();
    bfa_in_t r;
    int      pick;
    int      idx;
    r = make_req(CMD_ALLOC, '0, 1'($urandom), 1'($urandom));
    pick = $urandom_range(99);
    if (pick >= 45) begin
      if (pick < 70 && held_frames.size() != 0) begin
        idx = $urandom_range(held_frames.size() - 1);
        r.cmd = CMD_FREE;
        r.entry_frame = held_frames[idx];
        held_frames.delete(idx);
      end else if (pick < 80) begin
        r.entry_frame = FRAME_W'($urandom_range(4095, 1));
      end else if (pick < 88) begin
        r.cmd = CMD_FREE;
        r.entry_frame = FRAME_W'($urandom);
      end else if (pick < 92) begin
        r.cmd = CMD_FREE;
      end else begin
        r = IN_W'($urandom);
      end
    end
    return r;
  endfunction

  // start stays high across back-to-back requests; it only drops for a gap
  task automatic send_request(input bfa_in_t r);
    int gap;
    gap = 0;
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    while ($urandom_range(99) < gap_pct && gap < 40) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every request has its result, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // total_frames is only changed with the block idle
  task automatic set_total(input logic [CFG_W-1:0] frames);
    drain();
    cfg_data <= frames;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] frames, input int pct, input int count);
    set_total(frames);
    gap_pct = pct;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset count of frames
    // frame zero is a real frame and goes out first
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b0));
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b0));
    // entry already holding a frame, highest and lowest
    send_request(make_req(CMD_ALLOC, 12'hFFF, 1'b1, 1'b1));
    send_request(make_req(CMD_ALLOC, 12'h001, 1'b0, 1'b0));
    // free of an empty entry
    send_request(make_req(CMD_FREE, '0, 1'b1, 1'b1));
    // frees: top frame never allocated, then a held one
    send_request(make_req(CMD_FREE, 12'hFFF, 1'b0, 1'b0));
    send_request(make_req(CMD_FREE, 12'h001, 1'b1, 1'b0));
    // the freed frame comes back as lowest free
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b1));
    send_request(make_req(CMD_FREE, 12'h800, 1'b1, 1'b1));

    // no frames under management: every fresh allocation reports full
    set_total(13'd0);
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));
    send_request(make_req(CMD_FREE, 12'h002, 1'b0, 1'b0));
    send_request(make_req(CMD_ALLOC, 12'h555, 1'b0, 1'b1));

    // partial word is never searched
    set_total(13'd31);
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b0));

    // single whole word
    set_total(13'd33);
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));

    // count beyond capacity clamps to the bitmap size
    set_total(13'h1FFF);
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b1));
    send_request(make_req(CMD_ALLOC, 12'hAAA, 1'b1, 1'b0));

    // random part; small pools fill up and hit the full case
    run_phase(13'd64, 0, 70);
    run_phase(13'd4096, 85, 70);
    run_phase(13'd96, 0, 60);
    run_phase(13'h1FFF, 32, 70);
    run_phase(13'd32, 85, 60);
    run_phase(13'd4096, 0, 70);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
